[sv/vlt_pkg.sv]
// Shared constants, types and codes for the voxel line traversal block.
`timescale 1ns / 1ps
package vlt_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_RUN    = 64;
  // Plane counters never exceed MAX_RUN, so each cross product fits here.
  localparam int N_BITS     = $clog2(MAX_RUN + 1);
  localparam int PROD_BITS  = COORD_BITS + N_BITS;
  localparam int CNT_BITS   = (MAX_RUN > 2) ? $clog2(MAX_RUN) : 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [CNT_BITS-1:0]   count_t;

  // One classified segment: start voxel, per-axis extent and direction,
  // and the six running cross products n_a * |d_b|.
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t ext_x;
    coord_t ext_y;
    coord_t ext_z;
    logic   neg_x;
    logic   neg_y;
    logic   neg_z;
    prod_t  t_xy;
    prod_t  t_xz;
    prod_t  t_yx;
    prod_t  t_yz;
    prod_t  t_zx;
    prod_t  t_zy;
  } seg_desc_t;

  typedef enum logic [1:0] {
    W_IDLE = 2'b01,
    W_RUN  = 2'b10
  } walk_state_t;

endpackage

[sv/vlt_if.sv]
// Valid/ready channel interfaces for segment requests and voxel results.
`timescale 1ns / 1ps
interface vlt_seg_if import vlt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface vlt_vox_if import vlt_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vox_x;
  coord_t vox_y;
  coord_t vox_z;
  logic   last;
  logic   truncated;

  modport source (output valid, vox_x, vox_y, vox_z, last, truncated, input ready);
  modport sink (input valid, vox_x, vox_y, vox_z, last, truncated, output ready);
endinterface

[sv/vlt_front.sv]
// Front end: accepts a segment request and classifies it into a walk descriptor.
`timescale 1ns / 1ps
module vlt_front import vlt_pkg::*; (
  vlt_seg_if.sink   seg,
  input  logic      queue_full,
  output logic      push,
  output seg_desc_t push_desc
);

  logic   neg_x, neg_y, neg_z;
  coord_t ext_x, ext_y, ext_z;
  logic   n0_x, n0_y, n0_z;

  assign seg.ready = !queue_full;
  assign push      = seg.valid && !queue_full;

  always_comb begin
    neg_x = seg.end_x < seg.start_x;
    neg_y = seg.end_y < seg.start_y;
    neg_z = seg.end_z < seg.start_z;
    ext_x = neg_x ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
    ext_y = neg_y ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
    ext_z = neg_z ? seg.start_z - seg.end_z : seg.end_z - seg.start_z;
    // positive axes cross one plane ahead, negative ones at the start plane
    n0_x  = !neg_x && (ext_x != '0);
    n0_y  = !neg_y && (ext_y != '0);
    n0_z  = !neg_z && (ext_z != '0);

    push_desc.pos_x = seg.start_x;
    push_desc.pos_y = seg.start_y;
    push_desc.pos_z = seg.start_z;
    push_desc.ext_x = ext_x;
    push_desc.ext_y = ext_y;
    push_desc.ext_z = ext_z;
    push_desc.neg_x = neg_x;
    push_desc.neg_y = neg_y;
    push_desc.neg_z = neg_z;
    push_desc.t_xy  = n0_x ? prod_t'(ext_y) : '0;
    push_desc.t_xz  = n0_x ? prod_t'(ext_z) : '0;
    push_desc.t_yx  = n0_y ? prod_t'(ext_x) : '0;
    push_desc.t_yz  = n0_y ? prod_t'(ext_z) : '0;
    push_desc.t_zx  = n0_z ? prod_t'(ext_x) : '0;
    push_desc.t_zy  = n0_z ? prod_t'(ext_y) : '0;
  end

endmodule

[sv/vlt_queue.sv]
// Short descriptor queue between the front end and the walker.
`timescale 1ns / 1ps
module vlt_queue import vlt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  seg_desc_t push_desc,
  output logic      full,
  input  logic      pop,
  output seg_desc_t pop_desc,
  output logic      empty
);

  seg_desc_t             mem [Q_DEPTH];
  logic [Q_AW-1:0]       wr_ptr;
  logic [Q_AW-1:0]       rd_ptr;
  logic [Q_CW-1:0]       fill;

  assign full     = (fill == Q_CW'(Q_DEPTH));
  assign empty    = (fill == '0);
  assign pop_desc = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/vlt_walker.sv]
// Back end: walks one segment voxel by voxel into a registered output.
`timescale 1ns / 1ps
module vlt_walker import vlt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      queue_empty,
  input  seg_desc_t pop_desc,
  output logic      pop,
  vlt_vox_if.source vox
);

  walk_state_t state;
  coord_t      pos_x, pos_y, pos_z;
  coord_t      ext_x, ext_y, ext_z;
  coord_t      rem_x, rem_y, rem_z;
  logic        neg_x, neg_y, neg_z;
  prod_t       t_xy, t_xz, t_yx, t_yz, t_zx, t_zy;
  count_t      count;

  logic        out_valid;
  coord_t      out_x, out_y, out_z;
  logic        out_last, out_trunc;

  logic        load_ok, emit;
  logic        mv_x, mv_y, mv_z;
  logic        sel_x, sel_y, sel_z;
  logic        at_end, moved, over, cap;
  logic        emit_last, emit_trunc;

  assign vox.valid     = out_valid;
  assign vox.vox_x     = out_x;
  assign vox.vox_y     = out_y;
  assign vox.vox_z     = out_z;
  assign vox.last      = out_last;
  assign vox.truncated = out_trunc;

  assign load_ok = !out_valid || vox.ready;
  assign emit    = (state == W_RUN) && load_ok;
  assign pop     = (state == W_IDLE) && !queue_empty;

  always_comb begin
    mv_x   = ext_x != '0;
    mv_y   = ext_y != '0;
    mv_z   = ext_z != '0;
    at_end = (rem_x == '0) && (rem_y == '0) && (rem_z == '0);
    // nearest crossing steps; ties go to y over x and to z over y
    sel_x  = mv_x && (!mv_y || (t_xy < t_yx)) && (!mv_z || (t_xz < t_zx));
    sel_y  = !sel_x && mv_y && (!mv_z || (t_yz < t_zy));
    sel_z  = !sel_x && !sel_y && mv_z;
    moved  = sel_x || sel_y || sel_z;
    over   = (sel_x && rem_x == '0) || (sel_y && rem_y == '0) ||
             (sel_z && rem_z == '0);
    cap    = count == CNT_BITS'(MAX_RUN - 1);
    emit_last  = at_end || !moved || over || cap;
    emit_trunc = !at_end && moved && !over && cap;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= pos_x;
      out_y     <= pos_y;
      out_z     <= pos_z;
      out_last  <= emit_last;
      out_trunc <= emit_trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ok) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      count <= '0;
    end else begin
      case (state)
        W_IDLE: begin
          if (pop) begin
            state <= W_RUN;
            count <= '0;
          end
        end
        W_RUN: begin
          if (emit) begin
            if (emit_last) begin
              state <= W_IDLE;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        default: begin
          state <= W_IDLE;
        end
      endcase
    end
  end

  // walk registers: load from the queue, advance one voxel per emitted request
  always_ff @(posedge clk) begin
    if (pop) begin
      pos_x <= pop_desc.pos_x;
      pos_y <= pop_desc.pos_y;
      pos_z <= pop_desc.pos_z;
      ext_x <= pop_desc.ext_x;
      ext_y <= pop_desc.ext_y;
      ext_z <= pop_desc.ext_z;
      rem_x <= pop_desc.ext_x;
      rem_y <= pop_desc.ext_y;
      rem_z <= pop_desc.ext_z;
      neg_x <= pop_desc.neg_x;
      neg_y <= pop_desc.neg_y;
      neg_z <= pop_desc.neg_z;
      t_xy  <= pop_desc.t_xy;
      t_xz  <= pop_desc.t_xz;
      t_yx  <= pop_desc.t_yx;
      t_yz  <= pop_desc.t_yz;
      t_zx  <= pop_desc.t_zx;
      t_zy  <= pop_desc.t_zy;
    end else if (emit && !emit_last) begin
      if (sel_x) begin
        pos_x <= neg_x ? pos_x - 1'b1 : pos_x + 1'b1;
        rem_x <= rem_x - 1'b1;
        t_xy  <= t_xy + prod_t'(ext_y);
        t_xz  <= t_xz + prod_t'(ext_z);
      end
      if (sel_y) begin
        pos_y <= neg_y ? pos_y - 1'b1 : pos_y + 1'b1;
        rem_y <= rem_y - 1'b1;
        t_yx  <= t_yx + prod_t'(ext_x);
        t_yz  <= t_yz + prod_t'(ext_z);
      end
      if (sel_z) begin
        pos_z <= neg_z ? pos_z - 1'b1 : pos_z + 1'b1;
        rem_z <= rem_z - 1'b1;
        t_zx  <= t_zx + prod_t'(ext_x);
        t_zy  <= t_zy + prod_t'(ext_y);
      end
    end
  end

  a_trunc_is_last: assert property (@(posedge clk) disable iff (rst)
    emit && emit_trunc |-> emit_last)
    else $error("truncated voxel without last");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == W_RUN)
    else $error("walker did not start after queue pop");

  a_one_axis: assert property (@(posedge clk) disable iff (rst)
    $countones({sel_x, sel_y, sel_z}) <= 1)
    else $error("more than one axis selected");

  a_step_x: assert property (@(posedge clk) disable iff (rst)
    emit && !emit_last && sel_x |=> rem_x == $past(rem_x) - 1'b1)
    else $error("x remaining steps not decremented");

endmodule

[sv/voxel_line_traversal.sv]
// Top level: 6-connected voxel walk along a segment, front end, queue and walker.
//
//   channel | dir | handshake     | payload
//   seg     | in  | valid / ready | start_x/y/z, end_x/y/z (12 bits each)
//   vox     | out | valid / ready | vox_x/y/z, last, truncated
//
// A segment of L voxels (1..MAX_RUN) is walked in the walker by loading the
// descriptor from the queue, then one voxel per cycle set by the single step
// unit while the vox channel does not stall. The front end classifies in the
// accept cycle and the two-entry queue takes new requests while a walk is
// running. Synchronous reset empties the queue and idles the walker.
// A stalled vox channel holds the output register and freezes the walk.
`timescale 1ns / 1ps
module voxel_line_traversal import vlt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  vlt_seg_if.sink   seg,
  vlt_vox_if.source vox
);

  logic      push, pop, full, empty;
  seg_desc_t push_desc, pop_desc;

  vlt_front u_front (
    .seg        (seg),
    .queue_full (full),
    .push       (push),
    .push_desc  (push_desc)
  );

  vlt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .empty     (empty)
  );

  vlt_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (empty),
    .pop_desc    (pop_desc),
    .pop         (pop),
    .vox         (vox)
  );

endmodule

[sim/tb_top.sv]
// Testbench for voxel_line_traversal: segment stimulus, walk prediction and voxel checks.
`timescale 1ns / 1ps
module tb_top;
  import vlt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
  } segment_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    logic   truncated;
  } voxel_t;

  class voxel_path_sb;
    voxel_t expected_voxels[$];
    int     errors;
    int     segments;
    int     voxels;
    int     capped_runs;
    int     single_voxel_runs;

    function new();
      errors = 0;
      segments = 0;
      voxels = 0;
      capped_runs = 0;
      single_voxel_runs = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) begin
        $display("MISMATCH @%0t: %s", $time, msg);
      end
    endtask

    // Exact compare of plane crossings na/aa < nb/ab.
    function bit nearer(int na, int aa, int nb, int ab);
      return longint'(na) * longint'(ab) < longint'(nb) * longint'(aa);
    endfunction

    function void add_voxel(int x, int y, int z, bit last, bit truncated);
      voxel_t v;
      v.x = coord_t'(x);
      v.y = coord_t'(y);
      v.z = coord_t'(z);
      v.last = last;
      v.truncated = truncated;
      expected_voxels.push_back(v);
    endfunction

    // Walk one accepted segment and queue every voxel it visits.
    function void note_segment(segment_t s);
      int x1, y1, z1, dx, dy, dz, sx, sy, sz, ax, ay, az;
      int nx, ny, nz, ox, oy, oz, px, py, pz;
      int gx, gy, gz, hx, hy, hz, count;
      bit moved, done;
      x1 = int'(s.end_x);
      y1 = int'(s.end_y);
      z1 = int'(s.end_z);
      gx = int'(s.start_x);
      gy = int'(s.start_y);
      gz = int'(s.start_z);
      dx = x1 - gx;
      dy = y1 - gy;
      dz = z1 - gz;
      sx = (dx > 0) ? 1 : (dx < 0) ? -1 : 0;
      sy = (dy > 0) ? 1 : (dy < 0) ? -1 : 0;
      sz = (dz > 0) ? 1 : (dz < 0) ? -1 : 0;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      az = (dz < 0) ? -dz : dz;
      // Positive axes cross one plane ahead, negative ones at the start plane.
      nx = (dx > 0) ? 1 : 0;
      ny = (dy > 0) ? 1 : 0;
      nz = (dz > 0) ? 1 : 0;
      ox = 0;
      oy = 0;
      oz = 0;
      count = 0;
      done = 1'b0;
      segments++;
      if (dx == 0 && dy == 0 && dz == 0) begin
        single_voxel_runs++;
      end
      while (!done) begin
        hx = gx;
        hy = gy;
        hz = gz;
        px = ox;
        py = oy;
        pz = oz;
        moved = 1'b1;
        if (gx == x1 && gy == y1 && gz == z1) begin
          add_voxel(gx, gy, gz, 1'b1, 1'b0);
          done = 1'b1;
        end else begin
          if (sx != 0 && (sy == 0 || nearer(nx, ax, ny, ay)) &&
              (sz == 0 || nearer(nx, ax, nz, az))) begin
            hx += sx;
            px++;
          end else if (sy != 0 && (sz == 0 || nearer(ny, ay, nz, az))) begin
            hy += sy;
            py++;
          end else if (sz != 0) begin
            hz += sz;
            pz++;
          end else begin
            moved = 1'b0;
          end
          if (!moved || px > ax || py > ay || pz > az) begin
            // Drop the overshooting step and end here.
            add_voxel(gx, gy, gz, 1'b1, 1'b0);
            done = 1'b1;
          end else if (count + 1 >= MAX_RUN) begin
            add_voxel(gx, gy, gz, 1'b1, 1'b1);
            capped_runs++;
            done = 1'b1;
          end else begin
            add_voxel(gx, gy, gz, 1'b0, 1'b0);
            count++;
            if (px != ox) nx++;
            if (py != oy) ny++;
            if (pz != oz) nz++;
            ox = px;
            oy = py;
            oz = pz;
            gx = hx;
            gy = hy;
            gz = hz;
          end
        end
      end
    endfunction

    task check_voxel(voxel_t got);
      voxel_t want;
      if (expected_voxels.size() == 0) begin
        report($sformatf("unexpected voxel (%0d,%0d,%0d) last=%0b trunc=%0b",
                         got.x, got.y, got.z, got.last, got.truncated));
      end else begin
        want = expected_voxels.pop_front();
        voxels++;
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.last !== want.last || got.truncated !== want.truncated) begin
          report($sformatf("voxel (%0d,%0d,%0d) l=%0b t=%0b, want (%0d,%0d,%0d) l=%0b t=%0b",
                           got.x, got.y, got.z, got.last, got.truncated,
                           want.x, want.y, want.z, want.last, want.truncated));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  vlt_seg_if seg_ch ();
  vlt_vox_if vox_ch ();

  voxel_line_traversal u_dut (
    .clk (clk),
    .rst (rst),
    .seg (seg_ch),
    .vox (vox_ch)
  );

  voxel_path_sb sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d voxels still expected", cycle_count,
               sb.expected_voxels.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold: start it once on request and count it down here.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // Voxel receiver: check accepted results, stall at random or for a long hold.
  always @(posedge clk) begin
    voxel_t got;
    if (!rst && vox_ch.valid && vox_ch.ready) begin
      got.x = vox_ch.vox_x;
      got.y = vox_ch.vox_y;
      got.z = vox_ch.vox_z;
      got.last = vox_ch.last;
      got.truncated = vox_ch.truncated;
      sb.check_voxel(got);
    end
    if (hold_left > 0) begin
      vox_ch.ready <= 1'b0;
    end else begin
      vox_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic segment_t seg_of(int x0, int y0, int z0, int x1, int y1, int z1);
    segment_t s;
    s.start_x = coord_t'(x0);
    s.start_y = coord_t'(y0);
    s.start_z = coord_t'(z0);
    s.end_x = coord_t'(x1);
    s.end_y = coord_t'(y1);
    s.end_z = coord_t'(z1);
    return s;
  endfunction

  // Move by d, mirrored when that leaves the grid.
  function automatic coord_t shift_coord(coord_t c, int d);
    int v;
    v = int'(c) + d;
    if (v < 0 || v > COORD_MAX) v = int'(c) - d;
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_start();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return coord_t'(COORD_MAX);
    return coord_t'($urandom_range(0, COORD_MAX));
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int mode, span, d;
    mode = $urandom_range(0, 99);
    s.start_x = pick_start();
    s.start_y = pick_start();
    s.start_z = pick_start();
    if (mode < 88) begin
      // Mostly short walks, some medium ones.
      span = (mode < 70) ? 4 : 40;
      s.end_x = shift_coord(s.start_x, int'($urandom_range(0, 2 * span)) - span);
      s.end_y = shift_coord(s.start_y, int'($urandom_range(0, 2 * span)) - span);
      s.end_z = shift_coord(s.start_z, int'($urandom_range(0, 2 * span)) - span);
    end else if (mode < 94) begin
      s.end_x = coord_t'($urandom_range(0, COORD_MAX));
      s.end_y = coord_t'($urandom_range(0, COORD_MAX));
      s.end_z = coord_t'($urandom_range(0, COORD_MAX));
    end else begin
      // Equal extents on a random set of axes to force crossing ties.
      d = $urandom_range(0, 20);
      s.end_x = shift_coord(s.start_x, ($urandom_range(0, 1) ? d : -d) * $urandom_range(0, 1));
      s.end_y = shift_coord(s.start_y, ($urandom_range(0, 1) ? d : -d) * $urandom_range(0, 1));
      s.end_z = shift_coord(s.start_z, ($urandom_range(0, 1) ? d : -d) * $urandom_range(0, 1));
    end
    return s;
  endfunction

  task automatic send_segment(segment_t s);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      seg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= s.start_x;
    seg_ch.start_y <= s.start_y;
    seg_ch.start_z <= s.start_z;
    seg_ch.end_x <= s.end_x;
    seg_ch.end_y <= s.end_y;
    seg_ch.end_z <= s.end_z;
    do begin
      @(posedge clk);
    end while (!seg_ch.ready);
    sb.note_segment(s);
  endtask

  task automatic send_random(int n);
    repeat (n) send_segment(random_segment());
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    seg_ch.valid <= 1'b0;
    seg_ch.start_x <= '0;
    seg_ch.start_y <= '0;
    seg_ch.start_z <= '0;
    seg_ch.end_x <= '0;
    seg_ch.end_y <= '0;
    seg_ch.end_z <= '0;
    tx_idle_pct = 15;
    rx_idle_pct = 51;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-voxel runs at both corners of the grid.
    send_segment(seg_of(0, 0, 0, 0, 0, 0));
    send_segment(seg_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    // One moving axis in each direction.
    send_segment(seg_of(0, 7, 9, 5, 7, 9));
    send_segment(seg_of(COORD_MAX, 7, 9, COORD_MAX - 5, 7, 9));
    send_segment(seg_of(3, 0, 9, 3, 6, 9));
    send_segment(seg_of(3, 100, 9, 3, 94, 9));
    send_segment(seg_of(3, 4, 0, 3, 4, 4));
    send_segment(seg_of(3, 4, COORD_MAX, 3, 4, COORD_MAX - 4));
    // Ties on two and three axes, both signs.
    send_segment(seg_of(10, 10, 10, 13, 13, 13));
    send_segment(seg_of(20, 20, 20, 17, 17, 17));
    send_segment(seg_of(0, 0, 50, 3, 3, 50));
    send_segment(seg_of(50, 0, 0, 50, 3, 3));
    send_segment(seg_of(0, 50, 0, 3, 50, 3));
    send_segment(seg_of(100, 200, 300, 97, 204, 299));
    send_segment(seg_of(500, 10, 800, 503, 2, 805));
    // Exactly at the length cap, and one past it.
    send_segment(seg_of(0, 0, 0, MAX_RUN - 1, 0, 0));
    send_segment(seg_of(0, 0, 0, MAX_RUN, 0, 0));
    // Full-grid diagonals run into the cap.
    send_segment(seg_of(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(seg_of(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
    send_segment(seg_of(0, COORD_MAX, 0, COORD_MAX, 0, COORD_MAX));

    send_random(140);
    tx_idle_pct = 51;
    rx_idle_pct = 15;
    send_random(150);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(20);
    // Hold the receiver off while requests keep coming, so the input backs up.
    hold_go = 1'b1;
    send_random(140);
    seg_ch.valid <= 1'b0;

    while (sb.expected_voxels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Walked %0d segments (%0d single-voxel, %0d cut at the %0d-voxel cap),",
             sb.segments, sb.single_voxel_runs, sb.capped_runs, MAX_RUN);
    $display("checked %0d voxels under random stalls and a long output hold, %0d mismatches",
             sb.voxels, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
